// ===== rtl/core/fxalu_pkg.sv =====
// Shared types and helpers for the Q24.8 fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fxalu_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL  = 4'd2,  OP_DIV   = 4'd3,
    OP_GT   = 4'd4,  OP_LT   = 4'd5,  OP_GE   = 4'd6,  OP_LE    = 4'd7,
    OP_EQ   = 4'd8,  OP_NE   = 4'd9,  OP_INC  = 4'd10, OP_DEC   = 4'd11,
    OP_MIN  = 4'd12, OP_MAX  = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  // result that rides along the pipeline
  typedef struct packed {
    op_t         op;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  st;
  } side_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // apply sign to a magnitude, saturate to the signed 32-bit range
  function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
    sat_t   o;
    logic [63:0] nm;
    nm = -m;
    o.ovf = 1'b0;
    if (neg) begin
      if (m > 64'h0000_0000_8000_0000) begin
        o.res = MIN_NEG;
        o.ovf = 1'b1;
      end else begin
        o.res = nm[31:0];
      end
    end else begin
      if (m > 64'h0000_0000_7fff_ffff) begin
        o.res = MAX_POS;
        o.ovf = 1'b1;
      end else begin
        o.res = m[31:0];
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// Pipelined signed fixed-point ALU, Q(32-FRAC_BITS).FRAC_BITS.
// Depends on fxalu_pkg.
// Each transaction passes the input register, the setup stage, the divider stages
//   and output register; throughput one transaction per cycle, busy stays low.
// Depth is set by the restoring divider: one quotient bit per stage, 32+FRAC_BITS.
// Every operation runs the full depth so results leave in issue order.
// rst_n (synchronous) clears the valid bits only; no result survives reset.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_operation,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic             out_valid,
  output logic signed [31:0] out_result_raw,
  output logic             out_compare_true,
  output logic [1:0]       out_status
);

  localparam int NW  = 32 + FRAC_BITS;  // dividend / quotient width
  localparam int LAT = NW + 3;

  // never stalls: the receiver cannot hold results off
  assign busy = 1'b0;

  // ---------------- input register ----------------
  logic              vin_r;
  fxalu_pkg::op_t    opin_r;
  logic [31:0]       ain_r, bin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= 1'b0;
    end else begin
      vin_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    opin_r <= fxalu_pkg::op_t'(in_operation);
    ain_r  <= in_operand_a;
    bin_r  <= in_operand_b;
  end

  // ---------------- stage 0: fast ops, multiply, divider setup ----------------
  logic [31:0] mag_a, mag_b;
  logic [32:0] sum_w, dif_w, inc_w, dec_w;
  logic        lt_w, gt_w, eq_w;
  logic [63:0] half_w, toint_m, fromint_m;
  fxalu_pkg::sat_t toint_s, fromint_s;
  fxalu_pkg::side_t side_nxt;

  assign mag_a  = ain_r[31] ? 32'(-ain_r) : ain_r;
  assign mag_b  = bin_r[31] ? 32'(-bin_r) : bin_r;
  assign sum_w  = {ain_r[31], ain_r} + {bin_r[31], bin_r};
  assign dif_w  = {ain_r[31], ain_r} - {bin_r[31], bin_r};
  assign inc_w  = {ain_r[31], ain_r} + 33'd1;
  assign dec_w  = {ain_r[31], ain_r} - 33'd1;
  assign lt_w   = $signed(ain_r) < $signed(bin_r);
  assign gt_w   = $signed(ain_r) > $signed(bin_r);
  assign eq_w   = ain_r == bin_r;
  assign half_w = 64'd1 << (FRAC_BITS - 1);
  assign toint_m   = ({32'd0, mag_a} + half_w) >> FRAC_BITS;
  assign fromint_m = {32'd0, mag_a} << FRAC_BITS;
  assign toint_s   = fxalu_pkg::sat_mag(toint_m, ain_r[31]);
  assign fromint_s = fxalu_pkg::sat_mag(fromint_m, ain_r[31]);

  // 33-bit sum saturates when its two top bits disagree
  function automatic fxalu_pkg::side_t sat33(input fxalu_pkg::op_t op, input logic [32:0] s);
    fxalu_pkg::side_t o;
    o.op  = op;
    o.cmp = 1'b0;
    o.st  = fxalu_pkg::ST_OK;
    o.res = s[31:0];
    if (s[32] != s[31]) begin
      o.res = s[32] ? fxalu_pkg::MIN_NEG : fxalu_pkg::MAX_POS;
      o.st  = fxalu_pkg::ST_OVF;
    end
    return o;
  endfunction

  always_comb begin
    side_nxt.op  = opin_r;
    side_nxt.res = 32'd0;
    side_nxt.cmp = 1'b0;
    side_nxt.st  = fxalu_pkg::ST_OK;
    unique case (opin_r)
      fxalu_pkg::OP_ADD:   side_nxt = sat33(opin_r, sum_w);
      fxalu_pkg::OP_SUB:   side_nxt = sat33(opin_r, dif_w);
      fxalu_pkg::OP_INC:   side_nxt = sat33(opin_r, inc_w);
      fxalu_pkg::OP_DEC:   side_nxt = sat33(opin_r, dec_w);
      fxalu_pkg::OP_GT:    side_nxt.cmp = gt_w;
      fxalu_pkg::OP_LT:    side_nxt.cmp = lt_w;
      fxalu_pkg::OP_GE:    side_nxt.cmp = !lt_w;
      fxalu_pkg::OP_LE:    side_nxt.cmp = !gt_w;
      fxalu_pkg::OP_EQ:    side_nxt.cmp = eq_w;
      fxalu_pkg::OP_NE:    side_nxt.cmp = !eq_w;
      fxalu_pkg::OP_MIN:   side_nxt.res = lt_w ? ain_r : bin_r;
      fxalu_pkg::OP_MAX:   side_nxt.res = gt_w ? ain_r : bin_r;
      fxalu_pkg::OP_TOINT: side_nxt.res = toint_s.res;
      fxalu_pkg::OP_FROMINT: begin
        side_nxt.res = fromint_s.res;
        side_nxt.st  = fromint_s.ovf ? fxalu_pkg::ST_OVF : fxalu_pkg::ST_OK;
      end
      fxalu_pkg::OP_MUL, fxalu_pkg::OP_DIV: begin
        side_nxt.res = 32'd0;  // filled in later
      end
      default: side_nxt.res = 32'd0;
    endcase
  end

  // divider pipeline arrays, index 0 is the setup stage
  logic                 v_r    [0:NW];
  fxalu_pkg::side_t     side_r [0:NW];
  logic [31:0]          rem_r  [0:NW];
  logic [NW-1:0]        q_r    [0:NW];
  logic [NW-1:0]        nsh_r  [0:NW];
  logic [31:0]          d_r    [0:NW];
  logic                 neg_r  [0:NW];
  logic [63:0]          prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= vin_r;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_nxt;
    prod_r    <= {32'd0, mag_a} * {32'd0, mag_b};
    rem_r[0]  <= 32'd0;
    q_r[0]    <= '0;
    nsh_r[0]  <= NW'(mag_a) << FRAC_BITS;
    d_r[0]    <= mag_b;
    neg_r[0]  <= ain_r[31] ^ bin_r[31];
  end

  // multiply rounding resolved in the first divider stage
  fxalu_pkg::sat_t mul_s;
  assign mul_s = fxalu_pkg::sat_mag((prod_r + half_w) >> FRAC_BITS, neg_r[0]);

  // ---------------- divider stages: one quotient bit each ----------------
  for (genvar j = 1; j <= NW; j++) begin : g_div
    logic [32:0] rsh;
    logic        ge;
    assign rsh = {rem_r[j-1], nsh_r[j-1][NW-1]};
    assign ge  = rsh >= {1'b0, d_r[j-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? 32'(rsh - {1'b0, d_r[j-1]}) : rsh[31:0];
      q_r[j]   <= {q_r[j-1][NW-2:0], ge};
      nsh_r[j] <= nsh_r[j-1] << 1;
      d_r[j]   <= d_r[j-1];
      neg_r[j] <= neg_r[j-1];
      if (j == 1 && side_r[j-1].op == fxalu_pkg::OP_MUL) begin
        side_r[j].op  <= side_r[j-1].op;
        side_r[j].res <= mul_s.res;
        side_r[j].cmp <= 1'b0;
        side_r[j].st  <= mul_s.ovf ? fxalu_pkg::ST_OVF : fxalu_pkg::ST_OK;
      end else begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // ---------------- output stage: divide rounding and select ----------------
  logic            rnd_up;
  logic [63:0]     qmag;
  fxalu_pkg::sat_t div_s;

  // round half away from zero: bump when 2r >= d
  assign rnd_up = {rem_r[NW], 1'b0} >= {1'b0, d_r[NW]};
  assign qmag   = 64'(q_r[NW]) + 64'(rnd_up);
  assign div_s  = fxalu_pkg::sat_mag(qmag, neg_r[NW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (side_r[NW].op == fxalu_pkg::OP_DIV) begin
      out_compare_true <= 1'b0;
      if (d_r[NW] == 32'd0) begin
        out_result_raw <= 32'd0;
        out_status     <= fxalu_pkg::ST_DIV0;
      end else begin
        out_result_raw <= div_s.res;
        out_status     <= div_s.ovf ? fxalu_pkg::ST_OVF : fxalu_pkg::ST_OK;
      end
    end else begin
      out_result_raw   <= side_r[NW].res;
      out_compare_true <= side_r[NW].cmp;
      out_status       <= side_r[NW].st;
    end
  end

  // ---------------- assertions ----------------
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("transaction lost in pipeline");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a transaction");

  a_cmp_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_compare_true) |-> (out_result_raw == 32'd0 &&
                                         out_status == fxalu_pkg::ST_OK))
    else $error("compare result carries data");

  a_div0_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fxalu_pkg::ST_DIV0) |-> out_result_raw == 32'd0)
    else $error("divide by zero must give zero");

endmodule
`default_nettype wire
